// ----- rtl/core/hts_pkg.sv -----
package hts_pkg;

    localparam int MAX_ENTITIES_DEF = 256;
    localparam int SINE_DEPTH_DEF   = 1024;
    localparam int IN_DATA_W        = 256;
    localparam int OUT_DATA_W       = 136;
    localparam int ANGLE_W          = 16;
    localparam int TRIG_W           = 18;
    localparam int WORD_W           = 32;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic signed [TRIG_W-1:0] sine_q16(input logic [63:0] t);
        logic [1:0]         quad;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic [63:0]        q;
        quad = t[31:30];
        r    = {34'd0, t[29:0]};
        if (quad[0])
        begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        s    = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        s    = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        s    = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        s    = s + $signed(term);
        if (s < 0)
        begin
            s = 64'sd0;
        end
        q = ($unsigned(s) + 64'd8192) >> 14;
        return quad[1] ? -$signed(TRIG_W'(q)) : $signed(TRIG_W'(q));
    endfunction

endpackage

// ----- rtl/core/hts_sine_rom.sv -----
module hts_sine_rom #(
    parameter int SINE_TABLE_DEPTH = hts_pkg::SINE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic [hts_pkg::ANGLE_W-1:0]            angle,
    output logic signed [hts_pkg::TRIG_W-1:0]      data
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = 17 + IW;

    logic signed [hts_pkg::TRIG_W-1:0] tab [SINE_TABLE_DEPTH];
    logic [PW-1:0]                     prod;
    logic [IW-1:0]                     idx;

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++)
    begin : g_tab
        localparam logic [63:0] T_I = (64'(i) << 32) / SINE_TABLE_DEPTH;
        assign tab[i] = hts_pkg::sine_q16(T_I);
    end

    assign prod = PW'(angle) * PW'(SINE_TABLE_DEPTH);
    assign idx  = prod[PW-2:16];

    always_ff @(posedge clk)
    begin
        data <= tab[idx];
    end

endmodule

// ----- rtl/core/hts_store.sv -----
module hts_store #(
    parameter int DEPTH = hts_pkg::MAX_ENTITIES_DEF * 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [hts_pkg::WORD_W-1:0]    wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [hts_pkg::WORD_W-1:0]    rdata
);

    logic [hts_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/hts_out.sv -----
module hts_out (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [15:0][hts_pkg::WORD_W-1:0]     matrix,
    output logic                                 busy,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hts_pkg::OUT_DATA_W-1:0]       m_tdata,   // column_number, element_row0..3
    output logic                                 m_tlast    // last_column
);

    logic [15:0][hts_pkg::WORD_W-1:0] buf_reg;
    logic                             busy_reg;
    logic [1:0]                       col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            col_reg  <= 2'd0;
        end
        else if (busy_reg && m_tready)
        begin
            if (col_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= matrix;
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tlast  = (col_reg == 2'd3);
    assign m_tdata  = {6'd0, buf_reg[{col_reg, 2'd3}], buf_reg[{col_reg, 2'd2}],
                       buf_reg[{col_reg, 2'd1}], buf_reg[{col_reg, 2'd0}], col_reg};

endmodule

// ----- rtl/core/hts_engine.sv -----
module hts_engine #(
    parameter int MAX_ENTITIES = hts_pkg::MAX_ENTITIES_DEF,
    localparam int EW = $clog2(MAX_ENTITIES),
    localparam int AW = EW + 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hts_pkg::IN_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    output logic [hts_pkg::ANGLE_W-1:0]          rom_angle,
    input  logic signed [hts_pkg::TRIG_W-1:0]    rom_data,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output logic [hts_pkg::WORD_W-1:0]           mem_wdata,
    output logic [AW-1:0]                        mem_raddr,
    input  logic [hts_pkg::WORD_W-1:0]           mem_rdata,
    input  logic                                 out_busy,
    output logic                                 out_load,
    output logic [15:0][hts_pkg::WORD_W-1:0]     matrix
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_ROT, ST_SCL, ST_PLOAD, ST_DOT, ST_WRITE, ST_HAND
    } state_t;

    localparam int SX = 0;
    localparam int CX = 1;
    localparam int SY = 2;
    localparam int CY = 3;
    localparam int SZ = 4;
    localparam int CZ = 5;

    state_t      state_reg;
    logic [6:0]  step_reg;
    logic [6:0]  cidx;

    logic [7:0]  ent_reg;
    logic [7:0]  par_reg;
    logic        use_par_reg;
    logic        ent_ok_reg;
    logic [15:0] ang_reg [3];
    logic signed [31:0] scl_reg [3];
    logic signed [17:0] sc_reg [6];
    logic signed [33:0] a_reg;
    logic signed [33:0] b_reg;
    logic signed [51:0] acc_reg [4];
    logic signed [19:0] rot_reg [16];
    logic [15:0][31:0]  lm_reg;
    logic [15:0][31:0]  pm_reg;
    logic [15:0][31:0]  wm_reg;
    logic signed [65:0] dacc_reg;
    logic signed [66:0] prod_reg;

    logic signed [33:0] mult_a;
    logic signed [32:0] mult_b;
    logic [15:0]        ang_base;
    logic signed [31:0] scl_sel;
    logic signed [34:0] p35;
    logic signed [52:0] p53;
    logic signed [52:0] t53;
    logic signed [63:0] p64;
    logic signed [65:0] dsum;
    logic signed [65:0] dround;

    function automatic logic signed [19:0] rnd16(input logic signed [34:0] v);
        logic signed [35:0] t;
        t = 36'(v) + 36'sd32768;
        return 20'(t >>> 16);
    endfunction

    function automatic logic signed [19:0] rnd32(input logic signed [51:0] acc,
                                                 input logic signed [34:0] p);
        logic signed [53:0] t;
        t = 54'(acc) + (54'(p) <<< 16) + 54'sd2147483648;
        return 20'(t >>> 32);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] res;
        if (v > 50'sd2147483647)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = 32'(v);
        end
        return res;
    endfunction

    assign cidx      = step_reg - 7'd1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_HAND) && !out_busy;
    assign matrix    = wm_reg;
    assign mem_we    = (state_reg == ST_WRITE) && ent_ok_reg;
    assign mem_waddr = {EW'(ent_reg), step_reg[3:0]};
    assign mem_wdata = wm_reg[step_reg[3:0]];
    assign mem_raddr = {EW'(par_reg), step_reg[3:0]};

    assign p35    = prod_reg[34:0];
    assign p53    = prod_reg[52:0];
    assign t53    = p53 + 53'sd32768;
    assign p64    = prod_reg[63:0];
    assign dsum   = ((cidx[1:0] == 2'd0) ? 66'sd0 : dacc_reg) + 66'(p64);
    assign dround = dsum + 66'sd32768;

    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:    ang_base = ang_reg[0];
            2'd1:    ang_base = ang_reg[1];
            default: ang_base = ang_reg[2];
        endcase
        rom_angle = step_reg[0] ? ang_base + 16'h4000 : ang_base;
    end

    always_comb
    begin
        unique case (step_reg[3:2])
            2'd0:    scl_sel = scl_reg[0];
            2'd1:    scl_sel = scl_reg[1];
            2'd2:    scl_sel = scl_reg[2];
            default: scl_sel = 32'sd0;
        endcase
    end

    always_comb
    begin
        mult_a = 34'sd0;
        mult_b = 33'sd0;
        unique case (state_reg)
            ST_ROT:
            begin
                case (step_reg[3:0])
                    4'd0:    begin mult_a = 34'(sc_reg[SX]); mult_b = 33'(sc_reg[SY]); end
                    4'd1:    begin mult_a = 34'(sc_reg[CX]); mult_b = 33'(sc_reg[SY]); end
                    4'd2:    begin mult_a = a_reg;           mult_b = 33'(sc_reg[CZ]); end
                    4'd3:    begin mult_a = a_reg;           mult_b = 33'(sc_reg[SZ]); end
                    4'd4:    begin mult_a = b_reg;           mult_b = 33'(sc_reg[CZ]); end
                    4'd5:    begin mult_a = b_reg;           mult_b = 33'(sc_reg[SZ]); end
                    4'd6:    begin mult_a = 34'(sc_reg[CX]); mult_b = 33'(sc_reg[SZ]); end
                    4'd7:    begin mult_a = 34'(sc_reg[CX]); mult_b = 33'(sc_reg[CZ]); end
                    4'd8:    begin mult_a = 34'(sc_reg[SX]); mult_b = 33'(sc_reg[SZ]); end
                    4'd9:    begin mult_a = 34'(sc_reg[SX]); mult_b = 33'(sc_reg[CZ]); end
                    4'd10:   begin mult_a = 34'(sc_reg[CY]); mult_b = 33'(sc_reg[CZ]); end
                    4'd11:   begin mult_a = 34'(sc_reg[CY]); mult_b = 33'(sc_reg[SZ]); end
                    4'd12:   begin mult_a = 34'(sc_reg[SX]); mult_b = 33'(sc_reg[CY]); end
                    4'd13:   begin mult_a = 34'(sc_reg[CX]); mult_b = 33'(sc_reg[CY]); end
                    default: ;
                endcase
            end
            ST_SCL:
            begin
                mult_a = 34'(rot_reg[step_reg[3:0]]);
                mult_b = 33'(scl_sel);
            end
            ST_DOT:
            begin
                mult_a = 34'($signed(pm_reg[{step_reg[1:0], step_reg[3:2]}]));
                mult_b = 33'($signed(lm_reg[{step_reg[5:4], step_reg[1:0]}]));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 7'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_FETCH;
                        step_reg  <= 7'd0;
                    end
                end
                ST_FETCH:
                begin
                    if (step_reg == 7'd6)
                    begin
                        state_reg <= ST_ROT;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_ROT:
                begin
                    if (step_reg == 7'd14)
                    begin
                        state_reg <= ST_SCL;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_SCL:
                begin
                    if (step_reg == 7'd16)
                    begin
                        state_reg <= use_par_reg ? ST_PLOAD : ST_WRITE;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_PLOAD:
                begin
                    if (step_reg == 7'd16)
                    begin
                        state_reg <= ST_DOT;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_DOT:
                begin
                    if (step_reg == 7'd64)
                    begin
                        state_reg <= ST_WRITE;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_WRITE:
                begin
                    if (step_reg == 7'd15)
                    begin
                        state_reg <= ST_HAND;
                        step_reg  <= 7'd0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                ST_HAND:
                begin
                    if (!out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(mult_a) * 67'(mult_b);
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ent_reg     <= s_tdata[7:0];
                    par_reg     <= s_tdata[15:8];
                    use_par_reg <= s_tuser && (32'(s_tdata[15:8]) < MAX_ENTITIES);
                    ent_ok_reg  <= (32'(s_tdata[7:0]) < MAX_ENTITIES);
                    ang_reg[0]  <= s_tdata[127:112];
                    ang_reg[1]  <= s_tdata[143:128];
                    ang_reg[2]  <= s_tdata[159:144];
                    scl_reg[0]  <= s_tdata[191:160];
                    scl_reg[1]  <= s_tdata[223:192];
                    scl_reg[2]  <= s_tdata[255:224];
                    lm_reg[12]  <= s_tdata[47:16];
                    lm_reg[13]  <= s_tdata[79:48];
                    lm_reg[14]  <= s_tdata[111:80];
                    lm_reg[3]   <= 32'd0;
                    lm_reg[7]   <= 32'd0;
                    lm_reg[11]  <= 32'd0;
                    lm_reg[15]  <= 32'h0001_0000;
                    for (int i = 0; i < 16; i++)
                    begin
                        rot_reg[i] <= 20'sd0;
                    end
                end
            end
            ST_FETCH:
            begin
                if (step_reg != 7'd0)
                begin
                    sc_reg[cidx[2:0]] <= rom_data;
                end
            end
            ST_ROT:
            begin
                if (step_reg != 7'd0)
                begin
                    case (cidx[3:0])
                        4'd0:
                        begin
                            a_reg      <= prod_reg[33:0];
                            rot_reg[8] <= 20'(sc_reg[SY]);
                        end
                        4'd1:    b_reg      <= prod_reg[33:0];
                        4'd2:    acc_reg[0] <= prod_reg[51:0];
                        4'd3:    acc_reg[1] <= -prod_reg[51:0];
                        4'd4:    acc_reg[2] <= -prod_reg[51:0];
                        4'd5:    acc_reg[3] <= prod_reg[51:0];
                        4'd6:    rot_reg[1]  <= rnd32(acc_reg[0], p35);
                        4'd7:    rot_reg[5]  <= rnd32(acc_reg[1], p35);
                        4'd8:    rot_reg[2]  <= rnd32(acc_reg[2], p35);
                        4'd9:    rot_reg[6]  <= rnd32(acc_reg[3], p35);
                        4'd10:   rot_reg[0]  <= rnd16(p35);
                        4'd11:   rot_reg[4]  <= rnd16(-p35);
                        4'd12:   rot_reg[9]  <= rnd16(-p35);
                        4'd13:   rot_reg[10] <= rnd16(p35);
                        default: ;
                    endcase
                end
            end
            ST_SCL:
            begin
                if (step_reg != 7'd0 && cidx[1:0] != 2'd3 && cidx[3:2] != 2'd3)
                begin
                    lm_reg[cidx[3:0]] <= sat32(50'(t53 >>> 16));
                end
                if (step_reg == 7'd16)
                begin
                    wm_reg <= lm_reg;
                end
            end
            ST_PLOAD:
            begin
                if (step_reg != 7'd0)
                begin
                    pm_reg[cidx[3:0]] <= mem_rdata;
                end
            end
            ST_DOT:
            begin
                if (step_reg != 7'd0)
                begin
                    dacc_reg <= dsum;
                    if (cidx[1:0] == 2'd3)
                    begin
                        wm_reg[cidx[5:2]] <= sat32(50'(dround >>> 16));
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/hierarchical_trs_matrix.sv -----
// Builds the world matrix T*Rx*Ry*Rz*S of one entity per input beat, multiplies
// the stored world matrix of its parent on the left when has_parent is set and
// the parent slot is in range, stores the result in the entity's slot if that
// slot is in range and sends it as four output beats, column 0 first, tlast on
// column 3. Angles are binary angles looked up in a sine table; entries are
// Q16.16, saturated. A single 34x33 multiplier does all products, one per
// cycle, and the per-entity matrix store has one read and one write port:
// an item with a parent takes 16 parent word reads and 64 products more than
// one without. A parent slot must have been written before it is used; the
// next item is accepted while the previous matrix is still being sent.
module hierarchical_trs_matrix #(
    parameter int MAX_ENTITIES     = hts_pkg::MAX_ENTITIES_DEF,
    parameter int SINE_TABLE_DEPTH = hts_pkg::SINE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entity_index, parent_index, translate_x/y/z, angle_x/y/z, scale_x/y/z
    input  logic [hts_pkg::IN_DATA_W-1:0]      s_tdata,
    // has_parent
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // column_number, element_row0, element_row1, element_row2, element_row3
    output logic [hts_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    localparam int AW = $clog2(MAX_ENTITIES) + 4;

    logic [hts_pkg::ANGLE_W-1:0]         rom_angle;
    logic signed [hts_pkg::TRIG_W-1:0]   rom_data;
    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic [hts_pkg::WORD_W-1:0]          mem_wdata;
    logic [AW-1:0]                       mem_raddr;
    logic [hts_pkg::WORD_W-1:0]          mem_rdata;
    logic                                out_busy;
    logic                                out_load;
    logic [15:0][hts_pkg::WORD_W-1:0]    matrix;

    hts_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .angle (rom_angle),
        .data  (rom_data)
    );

    hts_store #(
        .DEPTH (MAX_ENTITIES * 16),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hts_engine #(
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .rom_angle (rom_angle),
        .rom_data  (rom_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_busy  (out_busy),
        .out_load  (out_load),
        .matrix    (matrix)
    );

    hts_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (out_load),
        .matrix   (matrix),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- tb/sv/hierarchical_trs_matrix_check.sv -----
`timescale 1ns / 1ps

module hierarchical_trs_matrix_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [hts_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [hts_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    output int                                fail_count,
    output int                                pending
);

    localparam int ENTITIES  = hts_pkg::MAX_ENTITIES_DEF;
    localparam int TAB_DEPTH = hts_pkg::SINE_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]       col;
        logic [3:0][31:0] rows;
        logic             last;
    } column_beat_t;

    column_beat_t column_fifo[$];
    longint       sine_lut[TAB_DEPTH];
    longint       world_store[ENTITIES*16];

    function automatic longint build_sine(int i);
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      s;
        longint      q;
        t = (64'(i) << 32) / TAB_DEPTH;
        r = t & 64'h3FFF_FFFF;
        if (t[30])
        begin
            r = 64'h4000_0000 - r;
        end
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        s    = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                s = s - longint'(term);
            else
                s = s + longint'(term);
        end
        if (s < 0)
        begin
            s = 0;
        end
        q = (s + 8192) >>> 14;
        return t[31] ? -q : q;
    endfunction

    function automatic longint sine_at(logic [15:0] a);
        longint idx;
        idx = (longint'(a) * TAB_DEPTH) >>> 16;
        if (idx >= TAB_DEPTH)
        begin
            idx = TAB_DEPTH - 1;
        end
        return sine_lut[idx];
    endfunction

    function automatic longint round_q(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 64'sd2147483647;
        if (v < -128'sd2147483648)
            return -64'sd2147483648;
        return longint'(v);
    endfunction

    task automatic predict_world(logic [hts_pkg::IN_DATA_W-1:0] d, logic with_parent);
        int                  ent;
        int                  par;
        longint              tr[3];
        longint              scl[3];
        longint              sx, cx, sy, cy, sz, cz;
        longint              rq[3][3];
        longint              loc[4][4];
        longint              wm[4][4];
        logic signed [127:0] acc;
        column_beat_t        beat;
        ent = d[7:0];
        par = d[15:8];
        for (int k = 0; k < 3; k++)
        begin
            tr[k]  = longint'($signed(d[16 + 32*k +: 32]));
            scl[k] = longint'($signed(d[160 + 32*k +: 32]));
        end
        sx = sine_at(d[127:112]);  cx = sine_at(d[127:112] + 16'd16384);
        sy = sine_at(d[143:128]);  cy = sine_at(d[143:128] + 16'd16384);
        sz = sine_at(d[159:144]);  cz = sine_at(d[159:144] + 16'd16384);
        rq[0][0] = cy * cz * 65536;
        rq[0][1] = -(cy * sz) * 65536;
        rq[0][2] = sy * 65536 * 65536;
        rq[1][0] = sx * sy * cz + cx * sz * 65536;
        rq[1][1] = -(sx * sy * sz) + cx * cz * 65536;
        rq[1][2] = -(sx * cy) * 65536;
        rq[2][0] = -(cx * sy * cz) + sx * sz * 65536;
        rq[2][1] = cx * sy * sz + sx * cz * 65536;
        rq[2][2] = cx * cy * 65536;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                loc[r][c] = clamp32(round_q(round_q(rq[r][c], 32) * scl[c], 16));
            loc[r][3] = tr[r];
        end
        loc[3][0] = 0; loc[3][1] = 0; loc[3][2] = 0; loc[3][3] = 65536;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (with_parent && par < ENTITIES)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc += 128'(world_store[par*16 + k*4 + r]) * 128'(loc[k][c]);
                    wm[r][c] = clamp32((acc + 128'sd32768) >>> 16);
                end
                else
                    wm[r][c] = loc[r][c];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            beat.col  = 2'(c);
            beat.last = (c == 3);
            for (int r = 0; r < 4; r++)
            begin
                beat.rows[r] = 32'(wm[r][c]);
                if (ent < ENTITIES)
                    world_store[ent*16 + c*4 + r] = wm[r][c];
            end
            column_fifo = {column_fifo, beat};
        end
    endtask

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < TAB_DEPTH; i++)
            sine_lut[i] = build_sine(i);
        for (int i = 0; i < ENTITIES*16; i++)
            world_store[i] = 0;
    end

    assign pending = column_fifo.size();

    always @(posedge clk)
    begin
        column_beat_t want;
        column_beat_t got;
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_world(s_tdata, s_tuser);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.col  = m_tdata[1:0];
            got.last = m_tlast;
            for (int r = 0; r < 4; r++)
                got.rows[r] = m_tdata[2 + 32*r +: 32];
            if (column_fifo.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual col %0d rows %h last %b",
                         $time, got.col, got.rows, got.last);
                fail_count++;
            end
            else
            begin
                want = column_fifo.pop_front();
                if (got.col !== want.col)
                begin
                    $display("%0t: column_number expected %0d actual %0d",
                             $time, want.col, got.col);
                    fail_count++;
                end
                for (int r = 0; r < 4; r++)
                begin
                    if (got.rows[r] !== want.rows[r])
                    begin
                        $display("%0t: col %0d row %0d expected %h actual %h",
                                 $time, want.col, r, want.rows[r], got.rows[r]);
                        fail_count++;
                    end
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last_column expected %b actual %b",
                             $time, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

endmodule

// ----- tb/sv/hierarchical_trs_matrix_test.sv -----
`timescale 1ns / 1ps

module hierarchical_trs_matrix_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ONE_Q16     = 65536;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [hts_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [hts_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                              m_tlast;
    int                                fail_count;
    int                                pending;
    int                                cycle_count;
    int                                item_count;
    int                                beat_count;
    int                                written_slots[$];
    bit                                slot_written[256];

    hierarchical_trs_matrix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    hierarchical_trs_matrix_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hierarchical_trs_matrix test failed");
            $finish;
        end
    end

    task automatic send_entity(int ent, bit with_parent, int par,
                               logic [2:0][31:0] trans, logic [2:0][15:0] ang,
                               logic [2:0][31:0] scl);
        int gap;
        gap = (item_count >= 60 && item_count < 80) ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= with_parent;
        s_tdata  <= {scl, ang, trans, 8'(par), 8'(ent)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        item_count++;
        if (!slot_written[ent])
        begin
            slot_written[ent] = 1'b1;
            written_slots = {written_slots, ent};
        end
    endtask

    function automatic logic [31:0] draw_word(bit is_scale);
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return is_scale ? 32'(ONE_Q16) : 32'($urandom_range(0, 4095));
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    task automatic send_random;
        int               ent;
        int               par;
        bit               with_parent;
        logic [2:0][31:0] trans;
        logic [2:0][15:0] ang;
        logic [2:0][31:0] scl;
        ent = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
        with_parent = (written_slots.size() > 0) && ($urandom_range(0, 9) < 7);
        par = with_parent ? written_slots[$urandom_range(0, written_slots.size() - 1)]
                          : $urandom_range(0, 255);
        for (int k = 0; k < 3; k++)
        begin
            trans[k] = draw_word(0);
            scl[k]   = draw_word(1);
            ang[k]   = $urandom_range(0, 65535);
        end
        send_entity(ent, with_parent, par, trans, ang, scl);
    endtask

    initial
    begin
        int gap;
        m_tready = 1'b0;
        beat_count = 0;
        @(posedge rst_n);
        forever
        begin
            gap = (beat_count >= 100 && beat_count < 160) ? 0 : $urandom_range(0, 11);
            if (beat_count == 40)
                gap = 1200;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            beat_count++;
        end
    end

    initial
    begin
        cycle_count = 0;
        item_count  = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity-like, quadrant angles, field extremes
        send_entity(0, 0, 255, '0, '0, {3{32'(ONE_Q16)}});
        send_entity(1, 0, 0, {32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
                    {16'd16384, 16'd32768, 16'd49152}, {3{32'(ONE_Q16)}});
        send_entity(255, 0, 17, {3{32'h8000_0000}}, {3{16'hFFFF}}, {3{32'h7FFF_FFFF}});
        send_entity(2, 0, 0, {3{32'h7FFF_FFFF}}, {16'd64, 16'd0, 16'd8192},
                    {3{32'h8000_0000}});
        send_entity(3, 0, 0, '0, {16'd0, 16'd65535, 16'd16383},
                    {32'h0, 32'hFFFF_0000, 32'h0002_0000});
        send_entity(4, 1, 0, {32'h0003_0000, 32'h0, 32'hFFFE_0000},
                    {16'd8192, 16'd4096, 16'd40000}, {3{32'(ONE_Q16)}});
        send_entity(5, 1, 1, '0, {16'd12345, 16'd23456, 16'd34567},
                    {32'h0000_8000, 32'h0001_8000, 32'hFFFF_0000});
        send_entity(6, 1, 255, {3{32'h7FFF_FFFF}}, '0, {3{32'h7FFF_FFFF}});
        send_entity(7, 1, 2, {3{32'h8000_0000}}, {3{16'd100}}, {3{32'h8000_0000}});
        // self-parent: old slot read before rewrite
        send_entity(4, 1, 4, {32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
                    {16'd16384, 16'd0, 16'd0}, {3{32'(ONE_Q16)}});
        send_entity(4, 1, 4, '0, {16'd0, 16'd16384, 16'd16384}, {3{32'h0002_0000}});
        send_entity(8, 0, 4, {3{32'h0000_FFFF}}, {16'd32768, 16'd49152, 16'd65472},
                    {3{32'hFFFF_FFFF}});
        send_entity(9, 1, 8, {3{32'hFFFF_FFFF}}, {16'hAAAA, 16'h5555, 16'hF0F0},
                    {3{32'h0000_0001}});

        while (item_count < 120)
            send_random();
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("hierarchical_trs_matrix test passed");
        else
            $display("hierarchical_trs_matrix test failed");
        $finish;
    end

endmodule
